// ===== hw/rtl/mt64_pkg.sv =====
// mt64_pkg: constants, types and the tempering function of the mt19937-64 core
// used by the fill multiplier, the top level and the bench
`timescale 1ns / 1ps

package mt64_pkg;

  localparam int STATE_WORDS   = 312;
  localparam int MIDDLE_OFFSET = 156;
  localparam int IDX_W         = 9;

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(STATE_WORDS - 1);

  // command codes on func
  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_RESEED = 1'b1;

  localparam logic [63:0] TWIST_MATRIX = 64'hB5026F5AA96619E9;
  localparam logic [63:0] UPPER_BITS   = 64'hFFFFFFFF80000000;
  localparam logic [63:0] LOWER_BITS   = 64'h000000007FFFFFFF;
  localparam logic [63:0] FILL_MULT    = 64'd6364136223846793005;
  localparam logic [63:0] DEFAULT_SEED = 64'd1234567;

  localparam logic [63:0] TEMPER_B = 64'h5555555555555555;
  localparam logic [63:0] TEMPER_C = 64'h71D67FFFEDA60000;
  localparam logic [63:0] TEMPER_D = 64'hFFF7EEE000000000;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  function automatic logic [63:0] temper(input logic [63:0] v_in);
    logic [63:0] v;
    v = v_in;
    v = v ^ ((v >> 29) & TEMPER_B);
    v = v ^ ((v << 17) & TEMPER_C);
    v = v ^ ((v << 37) & TEMPER_D);
    v = v ^ (v >> 43);
    return v;
  endfunction

endpackage

// ===== hw/rtl/mt64_in_if.sv =====
// mt64_in_if: command channel of the mt19937-64 core (func, seed_value)
// valid/ready handshake, no dependencies
`timescale 1ns / 1ps

interface mt64_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] seed_value;

  modport source (output valid, output func, output seed_value, input ready);
  modport sink   (input valid, input func, input seed_value, output ready);
endinterface

// ===== hw/rtl/mt64_out_if.sv =====
// mt64_out_if: result channel of the mt19937-64 core (random_value)
// valid/ready handshake, no dependencies
`timescale 1ns / 1ps

interface mt64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

// ===== hw/rtl/mt64_fill_mul.sv =====
// mt64_fill_mul: low 64 bits of FILL_MULT * operand on one shared 32x32 multiplier
// depends on mt64_pkg
`timescale 1ns / 1ps

module mt64_fill_mul (
  input  logic               clk,
  input  logic               rst,
  input  mt64_pkg::mul_req_t req,
  output mt64_pkg::mul_rsp_t rsp
);

  localparam logic [31:0] A_LO = mt64_pkg::FILL_MULT[31:0];
  localparam logic [31:0] A_HI = mt64_pkg::FILL_MULT[63:32];

  logic        busy;
  logic        done;
  logic [1:0]  step;
  logic [63:0] x;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  // partial products: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
  always_comb begin
    mul_a = (step == 2'd2) ? A_HI : A_LO;
    mul_b = (step == 2'd1) ? x[63:32] : x[31:0];
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        x    <= req.operand;
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        case (step)
          2'd0: begin
            prod <= mul_p;
            step <= 2'd1;
          end
          2'd1: begin
            acc  <= prod;
            prod <= mul_p;
            step <= 2'd2;
          end
          2'd2: begin
            acc[63:32] <= acc[63:32] + prod[31:0];
            prod       <= mul_p;
            step       <= 2'd3;
          end
          default: begin
            acc[63:32] <= acc[63:32] + prod[31:0];
            busy       <= 1'b0;
            done       <= 1'b1;
            step       <= 2'd0;
          end
        endcase
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

// ===== hw/rtl/mt64_random_generator_core.sv =====
// mt64_random_generator_core: mt19937-64 generator with a 312-word state memory
// depends on mt64_pkg, mt64_in_if, mt64_out_if and mt64_fill_mul
`timescale 1ns / 1ps

// channel  dir  payload                          meaning
// cmd      in   func (1), seed_value (64)        0 draw one word, 1 reseed
// result   out  random_value (64)                tempered word, one per draw
//
// a draw reads the word at the index and its successor, then reads the
// word halfway around, then twists, writes back and loads the output register
// a reseed refills the state memory one word at a time through the shared
// 32x32 fill multiplier and gives no result
// after reset the same fill runs from seed 1234567, cmd not ready
// cmd is taken while a result waits; a draw holds before its write-back until
// the output register is free

module mt64_random_generator_core (
  input  logic            clk,
  input  logic            rst,
  mt64_in_if.sink         cmd,
  mt64_out_if.source      result
);

  localparam int IW = mt64_pkg::IDX_W;

  typedef enum logic [2:0] {
    ST_FILL_SEED,
    ST_FILL_START,
    ST_FILL_WAIT,
    ST_IDLE,
    ST_GEN_MID,
    ST_GEN_WRITE
  } state_t;

  state_t state;

  // state memory, one write port and two registered read ports
  logic [63:0] twist_words [mt64_pkg::STATE_WORDS];
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic [IW-1:0] rd_a_addr;
  logic [IW-1:0] rd_b_addr;
  logic [63:0]   rd_a_data;
  logic [63:0]   rd_b_data;

  // control and working registers
  logic [IW-1:0] word_index;
  logic [IW-1:0] fill_index;
  logic [63:0]   seed;
  logic [63:0]   prev;
  logic [63:0]   y;
  logic          out_valid;
  logic [63:0]   out_value;

  // index arithmetic, all wrapping at the state size
  logic [IW-1:0] next_index;
  logic [IW:0]   mid_sum;
  logic [IW-1:0] mid_index;

  logic [63:0] twisted;
  logic        out_free;

  mt64_pkg::mul_req_t mul_req;
  mt64_pkg::mul_rsp_t mul_rsp;

  mt64_fill_mul u_fill_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  always_comb begin
    next_index = (word_index == mt64_pkg::LAST_INDEX) ? '0 : word_index + 1'b1;
    mid_sum    = {1'b0, word_index} + (IW+1)'(mt64_pkg::MIDDLE_OFFSET);
    if (mid_sum >= (IW+1)'(mt64_pkg::STATE_WORDS)) begin
      mid_index = IW'(mid_sum - (IW+1)'(mt64_pkg::STATE_WORDS));
    end else begin
      mid_index = mid_sum[IW-1:0];
    end
  end

  // twist: upper bits of the current word, lower bits of its successor
  assign twisted = rd_a_data ^ (y >> 1) ^ (y[0] ? mt64_pkg::TWIST_MATRIX : 64'd0);

  assign out_free = !out_valid || result.ready;

  // fill step operand: prev ^ (prev >> 62)
  assign mul_req.start   = (state == ST_FILL_START);
  assign mul_req.operand = prev ^ (prev >> 62);

  // read address and write port steering
  always_comb begin
    rd_a_addr = word_index;
    rd_b_addr = next_index;
    if (state == ST_GEN_MID || state == ST_GEN_WRITE) begin
      rd_a_addr = mid_index;
    end
    wr_en   = 1'b0;
    wr_addr = word_index;
    wr_data = twisted;
    case (state)
      ST_FILL_SEED: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = seed;
      end
      ST_FILL_WAIT: begin
        wr_en   = mul_rsp.done;
        wr_addr = fill_index;
        wr_data = mul_rsp.product + 64'(fill_index);
      end
      ST_GEN_WRITE: begin
        wr_en = out_free;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      twist_words[wr_addr] <= wr_data;
    end
    rd_a_data <= twist_words[rd_a_addr];
    rd_b_data <= twist_words[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL_SEED;
      seed       <= mt64_pkg::DEFAULT_SEED;
      word_index <= '0;
      fill_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      // output register: loaded by a finished draw, emptied by a transfer
      if (state == ST_GEN_WRITE && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_FILL_SEED: begin
          prev       <= seed;
          fill_index <= IW'(1);
          word_index <= '0;
          state      <= ST_FILL_START;
        end
        ST_FILL_START: begin
          state <= ST_FILL_WAIT;
        end
        ST_FILL_WAIT: begin
          if (mul_rsp.done) begin
            prev <= wr_data;
            if (fill_index == mt64_pkg::LAST_INDEX) begin
              state <= ST_IDLE;
            end else begin
              fill_index <= fill_index + 1'b1;
              state      <= ST_FILL_START;
            end
          end
        end
        ST_IDLE: begin
          if (cmd.valid) begin
            if (cmd.func == mt64_pkg::FUNC_RESEED) begin
              seed  <= cmd.seed_value;
              state <= ST_FILL_SEED;
            end else begin
              state <= ST_GEN_MID;
            end
          end
        end
        ST_GEN_MID: begin
          y     <= (rd_a_data & mt64_pkg::UPPER_BITS) | (rd_b_data & mt64_pkg::LOWER_BITS);
          state <= ST_GEN_WRITE;
        end
        ST_GEN_WRITE: begin
          // hold here until the output register can take the word
          if (out_free) begin
            out_value  <= mt64_pkg::temper(twisted);
            word_index <= next_index;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign cmd.ready           = (state == ST_IDLE);
  assign result.valid        = out_valid;
  assign result.random_value = out_value;

endmodule

// ===== test/mt64_random_generator_core_tb.sv =====
// mt64_random_generator_core_tb: self-checking bench for the mt19937-64 core, draws and reseeds
// depends on mt64_pkg, mt64_in_if, mt64_out_if and the core itself
`timescale 1ns / 1ps

module mt64_random_generator_core_tb;

  // idle percentage for both sides, and the cycles left after the last result
  localparam int IDLE_PCT     = 36;
  localparam int DRAIN_CYCLES = 40;
  // receiver hold-off: starts after this many results, lasts this many cycles
  localparam int HOLD_AFTER   = 250;
  localparam int HOLD_CYCLES  = 600;
  // window of results in which neither side idles
  localparam int QUIET_FROM   = 600;
  localparam int QUIET_TO     = 900;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct {
    logic        func;
    logic [63:0] seed;
  } gen_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mt64_in_if  cmd ();
  mt64_out_if result ();

  mt64_random_generator_core dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd.sink),
    .result (result.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // commands waiting to be driven, and tempered words waiting to come out
  gen_cmd_t    cmd_backlog[$];
  logic [63:0] words_due[$];

  // private copy of the generator state
  logic [63:0] twist_state[mt64_pkg::STATE_WORDS];
  int          twist_pos;

  logic cmd_taken;
  int   words_checked = 0;
  int   mismatches = 0;
  int   hold_left;
  logic hold_done;
  logic quiet;

  assign quiet = (words_checked >= QUIET_FROM) && (words_checked < QUIET_TO);

  // init_genrand64 fill; the twist restarts from word 0
  task automatic refill_state(input logic [63:0] seed);
    logic [63:0] prev;
    twist_state[0] = seed;
    for (int i = 1; i < mt64_pkg::STATE_WORDS; i++) begin
      prev = twist_state[i-1];
      twist_state[i] = mt64_pkg::FILL_MULT * (prev ^ (prev >> 62)) + 64'(i);
    end
    twist_pos = 0;
  endtask

  function automatic logic [63:0] scramble_word(input logic [63:0] w);
    logic [63:0] t;
    t = w;
    t ^= (t >> 29) & 64'h5555555555555555;
    t ^= (t << 17) & 64'h71D67FFFEDA60000;
    t ^= (t << 37) & 64'hFFF7EEE000000000;
    t ^= (t >> 43);
    return t;
  endfunction

  // twist the word at the running index, advance it, return the tempered word
  function automatic logic [63:0] next_draw();
    int          cur;
    int          nxt;
    int          mid;
    logic [63:0] y;
    logic [63:0] w;
    cur = (twist_pos >= mt64_pkg::STATE_WORDS) ? 0 : twist_pos;
    nxt = (cur + 1) % mt64_pkg::STATE_WORDS;
    mid = (cur + mt64_pkg::MIDDLE_OFFSET) % mt64_pkg::STATE_WORDS;
    y = (twist_state[cur] & mt64_pkg::UPPER_BITS) | (twist_state[nxt] & mt64_pkg::LOWER_BITS);
    w = twist_state[mid] ^ (y >> 1) ^ (y[0] ? mt64_pkg::TWIST_MATRIX : 64'd0);
    twist_state[cur] = w;
    twist_pos = nxt;
    return scramble_word(w);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_cmd(input logic func, input logic [63:0] seed);
    gen_cmd_t c;
    c.func = func;
    c.seed = seed;
    cmd_backlog.push_back(c);
  endtask

  // seeds with a bias toward the extremes
  function automatic logic [63:0] pick_seed();
    case ($urandom_range(7))
      0:       return 64'd0;
      1:       return '1;
      default: return rand_word();
    endcase
  endfunction

  // driver: a new command only after the current one has transferred
  always @(negedge clk) begin : drive_cmd
    gen_cmd_t nxt;
    logic     go;
    if (rst) begin
      cmd.valid      <= 1'b0;
      cmd.func       <= mt64_pkg::FUNC_DRAW;
      cmd.seed_value <= '0;
    end else if (!cmd.valid || cmd_taken) begin
      go = (cmd_backlog.size() > 0) && (quiet || $urandom_range(99) >= IDLE_PCT);
      if (go) begin
        nxt = cmd_backlog.pop_front();
        cmd.valid      <= 1'b1;
        cmd.func       <= nxt.func;
        cmd.seed_value <= nxt.seed;
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // receiver hold-off, counted here so the sender keeps offering meanwhile
  always @(negedge clk) begin : receiver_hold
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_checked >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin : drive_ready
    if (rst || hold_left != 0) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // every accepted command updates the private state; a draw queues its word
  always @(posedge clk) begin : track_cmd
    if (rst) begin
      cmd_taken <= 1'b0;
      refill_state(mt64_pkg::DEFAULT_SEED);
    end else begin
      cmd_taken <= cmd.valid && cmd.ready;
      if (cmd.valid && cmd.ready) begin
        if (cmd.func == mt64_pkg::FUNC_RESEED) begin
          refill_state(cmd.seed_value);
        end else begin
          words_due.push_back(next_draw());
        end
      end
    end
  end

  // monitor: each result transfer against the oldest expected word
  always @(posedge clk) begin : check_result
    logic [63:0] want;
    if (!rst && result.valid && result.ready) begin
      if (words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result %h", result.random_value);
        end
      end else begin
        want = words_due.pop_front();
        if (result.random_value !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: random_value expected %h got %h",
                     words_checked, want, result.random_value);
          end
        end
      end
      words_checked++;
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    int n;
    int run_len;

    // words from the power-up seed first
    repeat (3) push_cmd(mt64_pkg::FUNC_DRAW, rand_word());
    // seed extremes, each followed by draws
    push_cmd(mt64_pkg::FUNC_RESEED, 64'd0);
    repeat (2) push_cmd(mt64_pkg::FUNC_DRAW, 64'd0);
    push_cmd(mt64_pkg::FUNC_RESEED, '1);
    repeat (2) push_cmd(mt64_pkg::FUNC_DRAW, '1);
    push_cmd(mt64_pkg::FUNC_RESEED, 64'h8000000000000000);
    push_cmd(mt64_pkg::FUNC_DRAW, 64'h8000000000000000);
    // the published reference seed
    push_cmd(mt64_pkg::FUNC_RESEED, 64'd5489);
    repeat (2) push_cmd(mt64_pkg::FUNC_DRAW, '1);
    // back-to-back reseeds, the second one wins
    push_cmd(mt64_pkg::FUNC_RESEED, mt64_pkg::DEFAULT_SEED);
    push_cmd(mt64_pkg::FUNC_RESEED, rand_word());
    repeat (2) push_cmd(mt64_pkg::FUNC_DRAW, rand_word());
    // reseed back to the power-up seed, then one long run that wraps the index
    // twice and carries the hold-off and the start of the window without idling
    push_cmd(mt64_pkg::FUNC_RESEED, mt64_pkg::DEFAULT_SEED);
    repeat (700) push_cmd(mt64_pkg::FUNC_DRAW, rand_word());

    // random runs: mostly short, now and then long enough to wrap the index
    n = 700;
    while (n < RANDOM_ITEMS) begin
      push_cmd(mt64_pkg::FUNC_RESEED, pick_seed());
      if ($urandom_range(9) == 0) begin
        push_cmd(mt64_pkg::FUNC_RESEED, pick_seed());
      end
      run_len = ($urandom_range(9) == 0) ? $urandom_range(313, 650) : $urandom_range(1, 60);
      repeat (run_len) push_cmd(mt64_pkg::FUNC_DRAW, rand_word());
      n += run_len;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (cmd_backlog.size() > 0 || cmd.valid) @(posedge clk);
    while (words_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && words_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // the timeout allows several times the expected run
  initial begin : watchdog
    #2_400_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== mt64_random_generator_core.f =====
hw/rtl/mt64_pkg.sv
hw/rtl/mt64_in_if.sv
hw/rtl/mt64_out_if.sv
hw/rtl/mt64_fill_mul.sv
hw/rtl/mt64_random_generator_core.sv
test/mt64_random_generator_core_tb.sv
